// ===== src/bgd_pkg.sv =====
// Shared types and constants for the binary grid dilation block.
package bgd_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_DIM    = 3;

    localparam int GW_W   = 9;
    localparam int GH_W   = 13;
    localparam int CFG_W  = 13;
    localparam int CFG_IDX_W = 1;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 3);

    // window columns kept in the cell chain (the newest column comes straight from the row stores)
    localparam int WIN_CELLS = 2;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

    typedef struct packed {
        logic grid_start;
        logic cell_blocked;
        logic pad;
    } t_in_word;

    typedef struct packed {
        logic out_valid;
        logic out_blocked;
        logic out_last;
    } t_out_word;

    // one window column: rows top, middle, bottom
    typedef struct packed {
        logic top;
        logic mid;
        logic bot;
    } t_col;

endpackage

// ===== src/bgd_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
module bgd_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/bgd_cell.sv =====
// One column cell of the 3x3 window chain.
module bgd_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  bgd_pkg::t_col i_col,
    output bgd_pkg::t_col o_col
);
    import bgd_pkg::*;

    t_col r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

// ===== src/binary_grid_dilation.sv =====
// Top level: streaming 3x3 binary dilation of a raster occupancy grid.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_word  (t_in_word)
//  out     | output    | o_out_valid / i_out_ready  | o_out_word (t_out_word)
//  cfg     | input     | i_cfg_wr (no wait)         | i_cfg_idx, i_cfg_data
//
// One word per clock unless the output stalls; a taken word sits in stage two
// for its row-store read, then updates the window; its result is registered out.
// The row stores are one 256x2 RAM; 256 entry-valid flops cleared by reset make
// unwritten entries read as zero, so there is no clearing pass after reset.
// A stalled output word is held in the output register while one more word
// waits in the second stage; input ready drops only when both are full.
module binary_grid_dilation (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  bgd_pkg::t_in_word              i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output bgd_pkg::t_out_word             o_out_word,
    input  logic                           i_cfg_wr,
    input  logic [bgd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bgd_pkg::CFG_W-1:0]      i_cfg_data
);
    import bgd_pkg::*;

    // configuration
    logic [GW_W-1:0]  r_gw;
    logic [GH_W-1:0]  r_gh;
    logic [GW_W-1:0]  w_dim;
    logic [GH_W-1:0]  h_dim;

    // input position
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] acc_col;
    logic [ROW_W-1:0] acc_row;
    logic [GW_W-1:0]  col_inc;
    logic             acc_cell;
    logic             accept;

    // second stage
    logic             r_s1_vld;
    logic [COL_W-1:0] r_s1_col;
    logic [ROW_W-1:0] r_s1_row;
    logic             r_s1_cell;
    logic             r_fwd;
    logic [1:0]       r_fwd_data;
    logic             r_rd_ok;
    logic [MAX_WIDTH-1:0] r_ent_vld;
    logic             s1_fire;
    logic [1:0]       ram_q;
    logic [1:0]       store_q;

    // window chain
    t_col             fresh;
    t_col             win_in  [WIN_CELLS];
    t_col             win_out [WIN_CELLS];

    // result
    logic             r_out_vld;
    t_out_word        r_out_word, n_out_word;
    logic [ROW_W-1:0] orow;
    logic [GW_W-1:0]  ocol;
    logic             res_vld;
    logic             interior;
    logic             res_val;

    // clamp the registers to the supported range
    always_comb begin
        if (r_gw < GW_W'(MIN_DIM)) begin
            w_dim = GW_W'(MIN_DIM);
        end else if (r_gw > GW_W'(MAX_WIDTH)) begin
            w_dim = GW_W'(MAX_WIDTH);
        end else begin
            w_dim = r_gw;
        end
        if (r_gh < GH_W'(MIN_DIM)) begin
            h_dim = GH_W'(MIN_DIM);
        end else if (r_gh > GH_W'(MAX_HEIGHT)) begin
            h_dim = GH_W'(MAX_HEIGHT);
        end else begin
            h_dim = r_gh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw <= GW_W'(MAX_WIDTH);
            r_gh <= GH_W'(256);
        end else if (i_cfg_wr) begin
            case (i_cfg_idx)
                REG_GRID_WIDTH:  r_gw <= i_cfg_data[GW_W-1:0];
                REG_GRID_HEIGHT: r_gh <= i_cfg_data[GH_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake
    assign s1_fire    = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || s1_fire;
    assign accept     = i_in_valid && o_in_ready;

    // position of the accepted word and of the next one
    always_comb begin
        acc_col  = i_in_word.grid_start ? '0 : r_col;
        acc_row  = i_in_word.grid_start ? '0 : r_row;
        acc_cell = i_in_word.cell_blocked & ~i_in_word.pad;
        col_inc  = {1'b0, acc_col} + GW_W'(1);
        n_col    = col_inc[COL_W-1:0];
        n_row    = acc_row;
        if (col_inc >= w_dim) begin
            n_col = '0;
            if ({1'b0, acc_row} < {1'b0, h_dim} + (ROW_W+1)'(2)) begin
                n_row = acc_row + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // row stores: bit 1 upper row, bit 0 middle row
    bgd_ram #(
        .DATA_W (2),
        .DEPTH  (MAX_WIDTH)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_col),
        .i_wdata ({store_q[0], r_s1_cell}),
        .i_re    (accept),
        .i_raddr (acc_col),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_ent_vld <= '0;
        end else begin
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_fire) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_fire) begin
                r_ent_vld[r_s1_col] <= 1'b1;
            end
        end
    end

    // the word leaving stage two writes the entry the new word reads: forward it
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col   <= acc_col;
            r_s1_row   <= acc_row;
            r_s1_cell  <= acc_cell;
            r_fwd      <= s1_fire && (r_s1_col == acc_col);
            r_fwd_data <= {store_q[0], r_s1_cell};
            r_rd_ok    <= r_ent_vld[acc_col];
        end
    end

    always_comb begin
        if (r_fwd) begin
            store_q = r_fwd_data;
        end else if (r_rd_ok) begin
            store_q = ram_q;
        end else begin
            store_q = '0;
        end
    end

    assign fresh = '{top: store_q[1], mid: store_q[0], bot: r_s1_cell};

    // newest column enters the last cell and moves toward cell 0
    genvar gi;
    generate
        for (gi = 0; gi < WIN_CELLS; gi++) begin : g_win
            if (gi == WIN_CELLS - 1) begin : g_head
                assign win_in[gi] = fresh;
            end else begin : g_link
                assign win_in[gi] = win_out[gi+1];
            end
            bgd_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (s1_fire),
                .i_col   (win_in[gi]),
                .o_col   (win_out[gi])
            );
        end
    endgenerate

    // result for the cell one row and one column behind the input
    always_comb begin
        if (r_s1_col != '0) begin
            orow    = r_s1_row - ROW_W'(1);
            ocol    = {1'b0, r_s1_col} - GW_W'(1);
            res_vld = r_s1_row >= ROW_W'(1);
        end else begin
            // column 0: the finished cell is the end of the row before last
            orow    = r_s1_row - ROW_W'(2);
            ocol    = w_dim - GW_W'(1);
            res_vld = r_s1_row >= ROW_W'(2);
        end
        res_vld = res_vld && ({1'b0, orow} < {1'b0, h_dim});

        interior = (orow != '0)
                && ({1'b0, orow} + (ROW_W+1)'(2) <= {1'b0, h_dim})
                && (ocol != '0)
                && ({1'b0, ocol} + (GW_W+1)'(2) <= {1'b0, w_dim})
                && (r_s1_col != '0);

        if (interior) begin
            res_val = (|win_out[0]) | (|win_out[WIN_CELLS-1]) | (|fresh);
        end else begin
            res_val = win_out[WIN_CELLS-1].mid;
        end

        n_out_word.out_valid   = res_vld;
        n_out_word.out_blocked = res_vld && res_val;
        n_out_word.out_last    = res_vld
                              && ({1'b0, orow} == {1'b0, h_dim} - (ROW_W+1)'(1))
                              && (ocol == w_dim - GW_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_fire) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

endmodule
